/* rtl/core/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the greedy box suppression core.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int MAX_KEPT_DEF   = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int AREA_W         = 32;
  localparam int THR_W          = 16;
  localparam int LIMIT_W        = 9;
  localparam int CFG_IDX_W      = 2;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd14746;
  localparam logic [THR_W-1:0]   DECAY_RESET = 16'd32768;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
  localparam logic [THR_W-1:0]   ONE_Q15     = 16'd32768;
  localparam logic [THR_W-1:0]   HALF_Q15    = 16'd16384;
  localparam logic [LIMIT_W-1:0] SEEN_MAX    = 9'd511;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERLAP = 2'd0,
    REG_DECAY   = 2'd1,
    REG_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

endpackage

/* rtl/core/greedy_box_nms_core.sv */
// ----------------------------------------------------------------------------
// greedy_box_nms_core
// Greedy box suppression with an adaptive overlap limit.
// ----------------------------------------------------------------------------
// Candidates arrive on the in_valid/in_ready channel sorted by falling score;
// each gives one result transaction on out_valid/out_ready telling whether
// it was kept. list_end closes a list and clears the kept set.
// Kept boxes live in a ring of MAX_KEPT cells. A considered candidate passes
// after acceptance through the area state, one full turn of the ring (one kept
// box against the four-stage compare unit per cycle), the drain states that
// empty the compare unit and the update state, which registers its result.
// A candidate beyond candidate_limit goes from acceptance straight to the
// update state. A new candidate is taken only in the idle state, once the last
// one is through its update; the ring turn sets the rate.
// The result sits in an output register, so a new candidate is taken while
// the receiver stalls; only the update of the next one waits for it. Reset
// (rst, synchronous) empties the list and loads register defaults. cfg_write
// acts at once, no handshake; a mid-list overlap write waits for list_end.
// ----------------------------------------------------------------------------
module greedy_box_nms_core #(
  parameter int MAX_KEPT   = gbn_pkg::MAX_KEPT_DEF,
  parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbn_pkg::THR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  box_left,
  input  logic signed [COORD_BITS-1:0]  box_top,
  input  logic signed [COORD_BITS-1:0]  box_right,
  input  logic signed [COORD_BITS-1:0]  box_bottom,
  input  logic [15:0]                   box_score,
  input  logic [15:0]                   box_index,
  input  logic                          list_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kept,
  output logic [15:0]                   kept_score,
  output logic [15:0]                   kept_index,
  output logic                          last_of_list
);
  import gbn_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int BOX_W = 4 * CB + AREA_W;
  localparam int IW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KW    = $clog2(MAX_KEPT + 1);
  localparam int PW    = 2 * (CB + 1);
  localparam int PX    = (PW > AREA_W) ? PW : AREA_W + 1;

  state_t state, state_next;

  // configuration and list state
  logic [THR_W-1:0]   overlap_thr, decay, live_thr;
  logic [LIMIT_W-1:0] limit, seen_count;
  logic [KW-1:0]      kept_count;

  // candidate registers
  logic signed [CB-1:0] c_x0, c_y0, c_x1, c_y1;
  logic [AREA_W-1:0]    c_area;
  logic [15:0]          c_score, c_index;
  logic                 c_last, considered, suppressed;

  logic [IW-1:0] scan_cnt;
  logic [1:0]    drain_cnt;

  logic in_fire, out_free, upd, keep, store, rotate, feed, fail;
  logic [BOX_W-1:0] cand_box;
  logic [BOX_W-1:0] ring [MAX_KEPT];

  logic signed [CB:0] aw, ah;
  logic [PW-1:0]      a_prod;
  logic [PX-1:0]      a_prod_x;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign keep     = considered && !suppressed;
  assign cand_box = {c_x0, c_y0, c_x1, c_y1, c_area};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (seen_count < limit) ? ST_AREA : ST_UPDATE;
        end
      end
      ST_AREA:   state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt == IW'(MAX_KEPT - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'd3) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rotate   = 1'b0;
    feed     = 1'b0;
    upd      = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SCAN: begin
        rotate = 1'b1;
        feed   = KW'(scan_cnt) < kept_count;
      end
      ST_UPDATE: upd = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign store = upd && keep && (kept_count < KW'(MAX_KEPT));

  // candidate area, saturated
  assign aw       = {c_x1[CB-1], c_x1} - {c_x0[CB-1], c_x0};
  assign ah       = {c_y1[CB-1], c_y1} - {c_y0[CB-1], c_y0};
  assign a_prod   = PW'($unsigned(aw)) * PW'($unsigned(ah));
  assign a_prod_x = PX'(a_prod);

  // candidate capture and per-item work
  always_ff @(posedge clk) begin
    if (in_fire) begin
      c_x0    <= box_left;
      c_y0    <= box_top;
      c_x1    <= box_right;
      c_y1    <= box_bottom;
      c_score <= box_score;
      c_index <= box_index;
      c_last  <= list_end;
    end
    if (state == ST_AREA) begin
      if (aw[CB] || ah[CB]) begin
        c_area <= '0;
      end else begin
        c_area <= (|a_prod_x[PX-1:AREA_W]) ? {AREA_W{1'b1}} : a_prod_x[AREA_W-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      overlap_thr  <= THR_RESET;
      decay        <= DECAY_RESET;
      limit        <= LIMIT_RESET;
      live_thr     <= THR_RESET;
      seen_count   <= '0;
      kept_count   <= '0;
      considered   <= 1'b0;
      suppressed   <= 1'b0;
      scan_cnt     <= '0;
      drain_cnt    <= '0;
      out_valid    <= 1'b0;
      kept         <= 1'b0;
      kept_score   <= '0;
      kept_index   <= '0;
      last_of_list <= 1'b0;
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          REG_OVERLAP: begin
            overlap_thr <= cfg_data;
            if (seen_count == '0) begin
              live_thr <= cfg_data;
            end
          end
          REG_DECAY: decay <= cfg_data;
          REG_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
          default: begin
            decay <= decay;
          end
        endcase
      end

      if (in_fire) begin
        considered <= seen_count < limit;
      end

      // scan bookkeeping
      if (state == ST_AREA) begin
        scan_cnt   <= '0;
        suppressed <= 1'b0;
      end
      if (state == ST_SCAN) begin
        scan_cnt   <= scan_cnt + 1'b1;
        drain_cnt  <= '0;
        suppressed <= suppressed | fail;
      end
      if (state == ST_DRAIN) begin
        drain_cnt  <= drain_cnt + 1'b1;
        suppressed <= suppressed | fail;
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // result and list update
      if (upd) begin
        out_valid    <= 1'b1;
        kept         <= keep;
        kept_score   <= c_score;
        kept_index   <= c_index;
        last_of_list <= c_last;
        if (c_last) begin
          seen_count <= '0;
          kept_count <= '0;
          live_thr   <= overlap_thr;
        end else begin
          if (seen_count != SEEN_MAX) begin
            seen_count <= seen_count + 1'b1;
          end
          if (store) begin
            kept_count <= kept_count + 1'b1;
          end
          if (keep && decay < ONE_Q15 && live_thr > HALF_Q15) begin
            live_thr <= THR_W'((32'(live_thr) * 32'(decay)) >> 15);
          end
        end
      end
    end
  end

  // ring of kept boxes, turning toward slot zero
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_ring
    gbn_cell #(
      .W(BOX_W)
    ) u_cell (
      .clk      (clk),
      .shift    (rotate),
      .load     (store && (kept_count == KW'(i))),
      .shift_in (ring[(i + 1) % MAX_KEPT]),
      .load_data(cand_box),
      .data_out (ring[i])
    );
  end

  gbn_cmp #(
    .CB(CB)
  ) u_cmp (
    .clk     (clk),
    .rst     (rst),
    .in_valid(feed),
    .cand    (cand_box),
    .kbox    (ring[0]),
    .thr     (live_thr),
    .fail    (fail)
  );

endmodule

/* rtl/core/gbn_cell.sv */
// ----------------------------------------------------------------------------
// gbn_cell
// One slot of the kept-box ring: holds a box, shifts from its neighbor.
// ----------------------------------------------------------------------------
module gbn_cell #(
  parameter int W = 96
) (
  input  logic         clk,
  input  logic         shift,
  input  logic         load,
  input  logic [W-1:0] shift_in,
  input  logic [W-1:0] load_data,
  output logic [W-1:0] data_out
);

  logic [W-1:0] data;

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= shift_in;
    end
  end

  assign data_out = data;

endmodule

/* rtl/core/gbn_cmp.sv */
// ----------------------------------------------------------------------------
// gbn_cmp
// Four-stage overlap test of the candidate against one kept box.
// ----------------------------------------------------------------------------
module gbn_cmp #(
  parameter int CB = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [4*CB+gbn_pkg::AREA_W-1:0] cand,
  input  logic [4*CB+gbn_pkg::AREA_W-1:0] kbox,
  input  logic [gbn_pkg::THR_W-1:0]  thr,
  output logic                       fail
);
  import gbn_pkg::*;

  localparam int PW = 2 * (CB + 1);
  localparam int PX = (PW > AREA_W) ? PW : AREA_W + 1;

  logic signed [CB-1:0] cx0, cy0, cx1, cy1, kx0, ky0, kx1, ky1;
  logic [AREA_W-1:0]    carea, karea;
  logic signed [CB-1:0] ix0, iy0, ix1, iy1;
  logic signed [CB:0]   iw, ih;

  // stage A registers
  logic              a_valid, a_disj, a_neg;
  logic [CB:0]       a_mw, a_mh;
  logic [AREA_W:0]   a_sum;
  // stage B registers
  logic              b_valid, b_disj, b_neg;
  logic [AREA_W-1:0] b_mag;
  logic [AREA_W:0]   b_sum;
  // stage C registers
  logic              c_valid, c_disj;
  logic signed [AREA_W+18:0] c_lhs;
  logic [AREA_W+16:0]        c_rhs;

  logic [PW-1:0]           prod;
  logic [PX-1:0]           prod_x;
  logic signed [AREA_W:0]  inter_s;
  logic signed [17:0]      t1;

  assign {cx0, cy0, cx1, cy1, carea} = cand;
  assign {kx0, ky0, kx1, ky1, karea} = kbox;

  // intersection corners and extents
  always_comb begin
    ix0 = (kx0 > cx0) ? kx0 : cx0;
    iy0 = (ky0 > cy0) ? ky0 : cy0;
    ix1 = (kx1 < cx1) ? kx1 : cx1;
    iy1 = (ky1 < cy1) ? ky1 : cy1;
    iw  = {ix1[CB-1], ix1} - {ix0[CB-1], ix0};
    ih  = {iy1[CB-1], iy1} - {iy0[CB-1], iy0};
  end

  always_ff @(posedge clk) begin
    a_disj <= (kx0 > cx1) || (kx1 < cx0) || (ky0 > cy1) || (ky1 < cy0);
    a_neg  <= iw[CB] ^ ih[CB];
    a_mw   <= iw[CB] ? $unsigned(-iw) : $unsigned(iw);
    a_mh   <= ih[CB] ? $unsigned(-ih) : $unsigned(ih);
    a_sum  <= {1'b0, carea} + {1'b0, karea};
  end

  // stage B: saturated intersection magnitude
  assign prod   = PW'(a_mw) * PW'(a_mh);
  assign prod_x = PX'(prod);

  always_ff @(posedge clk) begin
    b_disj <= a_disj;
    b_neg  <= a_neg;
    b_sum  <= a_sum;
    b_mag  <= (|prod_x[PX-1:AREA_W]) ? {AREA_W{1'b1}} : prod_x[AREA_W-1:0];
  end

  // stage C: both sides of inter*(t+1) <= (a1+a2)*t
  assign inter_s = b_neg ? -$signed({1'b0, b_mag}) : $signed({1'b0, b_mag});
  assign t1      = $signed({1'b0, 17'(thr) + 17'(ONE_Q15)});

  always_ff @(posedge clk) begin
    c_disj <= b_disj;
    c_lhs  <= (AREA_W+19)'(inter_s) * (AREA_W+19)'(t1);
    c_rhs  <= (AREA_W+17)'(b_sum) * (AREA_W+17)'(thr);
  end

  // stage D: suppression flag
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      fail    <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      fail    <= c_valid && !c_disj && (c_lhs > $signed({2'b00, c_rhs}));
    end
  end

endmodule
